// ----- hw/rtl/clnr_pkg.sv -----
// ----------------------------------------------------------------------------
// clnr_pkg
// Shared types, constants and helper functions of the character LCD
// nibble refresh controller.
// ----------------------------------------------------------------------------
package clnr_pkg;

    localparam int SLOTS_PER_LINE = 16;
    localparam int STORE_DEPTH    = 2 * SLOTS_PER_LINE;
    localparam int STORE_AW       = $clog2(STORE_DEPTH);
    localparam int SLOT_IW        = $clog2(SLOTS_PER_LINE);
    localparam int SLOT_CW        = $clog2(SLOTS_PER_LINE + 1);

    localparam logic [3:0] MODE_NIBBLE = 4'h2;
    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    localparam logic [7:0] RST_POWER_UP_DELAY   = 8'd5;
    localparam logic [7:0] RST_COMMAND_GAP      = 8'd1;
    localparam logic [7:0] RST_FUNCTION_SET     = 8'd40;
    localparam logic [7:0] RST_DISPLAY_CONTROL  = 8'd12;
    localparam logic [7:0] RST_LINE_ONE_ADDR    = 8'd128;
    localparam logic [7:0] RST_LINE_TWO_ADDR    = 8'd192;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_LEVEL = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_FUNC  = 2'd0,
        PH_DISP  = 2'd1,
        PH_MODE  = 2'd2,
        PH_DELAY = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        CFG_POWER_UP_DELAY  = 3'd0,
        CFG_COMMAND_GAP     = 3'd1,
        CFG_FUNCTION_SET    = 3'd2,
        CFG_DISPLAY_CONTROL = 3'd3,
        CFG_LINE_ONE_ADDR   = 3'd4,
        CFG_LINE_TWO_ADDR   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic                char_en;
        logic [STORE_AW-1:0] char_addr;
        logic [7:0]          char_data;
        logic                level_en;
        logic [7:0]          level;
    } store_wr_t;

    function automatic logic [7:0] banner_one(input logic [SLOT_IW-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h46;
            4'd1:    ch = 8'h4F;
            4'd2:    ch = 8'h42;
            4'd3:    ch = 8'h20;
            4'd4:    ch = 8'h54;
            4'd5:    ch = 8'h65;
            4'd6:    ch = 8'h73;
            4'd7:    ch = 8'h74;
            4'd8:    ch = 8'h65;
            4'd9:    ch = 8'h72;
            default: ch = BLANK_CHAR;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] banner_two(input logic [SLOT_IW-1:0] pos);
        logic [7:0] ch;
        case (pos)
            4'd0:    ch = 8'h4F;
            4'd1:    ch = 8'h6D;
            4'd2:    ch = 8'h61;
            4'd3:    ch = 8'h72;
            4'd4:    ch = 8'h20;
            4'd5:    ch = 8'h53;
            4'd6:    ch = 8'h65;
            4'd7:    ch = 8'h76;
            4'd8:    ch = 8'h69;
            4'd9:    ch = 8'h6C;
            4'd10:   ch = 8'h6C;
            4'd11:   ch = 8'h61;
            default: ch = BLANK_CHAR;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] banner_char(input logic [STORE_AW-1:0] addr);
        logic [7:0] ch;
        if (addr < STORE_AW'(SLOTS_PER_LINE)) begin
            ch = banner_one(addr[SLOT_IW-1:0]);
        end else begin
            ch = banner_two(SLOT_IW'(addr - STORE_AW'(SLOTS_PER_LINE)));
        end
        return ch;
    endfunction

    // hundreds digit of a byte: (v * 41) >> 12 is exact for v < 256
    function automatic logic [3:0] dec_hundreds(input logic [7:0] v);
        logic [13:0] p;
        p = 14'(v) * 14'd41;
        return {2'b00, p[13:12]};
    endfunction

    // tens digit of a value below 100: (v * 205) >> 11 is exact there
    function automatic logic [3:0] dec_tens(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

endpackage

// ----- hw/rtl/clnr_text_store.sv -----
// ----------------------------------------------------------------------------
// clnr_text_store
// Two-line character store with banner reset, a character write port,
// a three-digit decimal write of a byte at the start of line one, and
// one combinational read port.
// ----------------------------------------------------------------------------
module clnr_text_store
    import clnr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  store_wr_t           wr,
    input  logic [STORE_AW-1:0] rd_addr,
    output logic [7:0]          rd_data
);

    logic [7:0] store_reg [STORE_DEPTH];

    logic [3:0] hund;
    logic [6:0] rem_hund;
    logic [3:0] tens;
    logic [3:0] units;

    always_comb begin
        hund     = dec_hundreds(wr.level);
        rem_hund = 7'(wr.level - 8'(hund) * 8'd100);
        tens     = dec_tens(rem_hund);
        units    = 4'(rem_hund - 7'(tens) * 7'd10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= banner_char(STORE_AW'(i));
            end
        end else begin
            if (wr.char_en) begin
                store_reg[wr.char_addr] <= wr.char_data;
            end
            if (wr.level_en) begin
                store_reg[0] <= ASCII_ZERO + 8'(hund);
                store_reg[1] <= ASCII_ZERO + 8'(tens);
                store_reg[2] <= ASCII_ZERO + 8'(units);
            end
        end
    end

    assign rd_data = store_reg[rd_addr];

endmodule

// ----- hw/rtl/char_lcd_nibble_refresh_controller.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_refresh_controller
// Two-line character LCD controller on a 4-bit bus with endless refresh.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one item per handshake. Kind tick moves the LCD pins one
//   step and yields pin results on m_*; kinds write character and show
//   level only update the text store and yield nothing.
//   m_* channel: pin levels after each step; last marks the final result
//   of a tick. A tick yields one result the cycle after it is accepted;
//   the tick that ends line two yields three results in turn (strobe
//   done, 4-bit mode strobe high, then low). Throughput: one item per
//   cycle while m_ready stays high; the three-result tick holds s_ready
//   low while the single output register drains its tail. If m_ready is
//   low, the output register holds its result and s_ready drops until it
//   is taken. cfg_* channel: register writes, always ready; the user must
//   have them taken while idle, which the block does not enforce. Reset
//   (synchronous, aresetn low): registers return to defaults, the text
//   store reloads the banner, the power-up wait starts again.
// ----------------------------------------------------------------------------
module char_lcd_nibble_refresh_controller
    import clnr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic       s_line_select,
    input  logic [3:0] s_slot,
    input  logic [7:0] s_char_code,
    input  logic [7:0] s_level,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_reg_select,
    output logic       m_read_write,
    output logic [3:0] m_data_nibble,
    output logic       m_enable,
    output logic       m_ready_res,
    output logic       m_last
);

    // configuration registers
    logic [7:0] power_up_delay_reg, power_up_delay_next;
    logic [7:0] command_gap_reg, command_gap_next;
    logic [7:0] function_set_reg, function_set_next;
    logic [7:0] display_control_reg, display_control_next;
    logic [7:0] line_one_addr_reg, line_one_addr_next;
    logic [7:0] line_two_addr_reg, line_two_addr_next;

    // sequencer state
    logic [3:0]         pin_nibble_reg, pin_nibble_next;
    logic               pin_rs_reg, pin_rs_next;
    logic               pin_enable_reg, pin_enable_next;
    logic               low_half_reg, low_half_next;
    logic               init_done_reg, init_done_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         delay_count_reg, delay_count_next;
    phase_t             after_phase_reg, after_phase_next;
    logic               line_reg, line_next;
    logic [SLOT_CW-1:0] slot_count_reg, slot_count_next;

    // output register
    logic       m_valid_reg;
    logic [1:0] tail_reg;
    logic       m_rs_reg, m_enable_reg, m_ready_res_reg, m_last_reg;
    logic [3:0] m_nibble_reg;

    logic tick_acc, cfg_acc, in_acc;
    logic line_busy;
    logic restart;

    logic       send_active, send_rs;
    logic [7:0] send_byte;
    logic [3:0] step_nibble;
    logic       step_enable, step_low, step_done;

    logic       res_rs, res_enable, res_ready, res_last;
    logic [3:0] res_nibble;

    store_wr_t           store_wr;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          rd_data;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_ready   = !m_valid_reg || (m_ready && (tail_reg == 2'd0));
    assign in_acc    = s_valid && s_ready;
    assign tick_acc  = in_acc && (s_kind == KIND_TICK);
    assign line_busy = slot_count_reg < SLOT_CW'(SLOTS_PER_LINE);

    // text store
    always_comb begin
        store_wr.char_en   = in_acc && (s_kind == KIND_CHAR)
                             && ({1'b0, s_slot} < SLOT_CW'(SLOTS_PER_LINE));
        store_wr.char_addr = s_line_select ? STORE_AW'(SLOTS_PER_LINE) + STORE_AW'(s_slot)
                                           : STORE_AW'(s_slot);
        store_wr.char_data = s_char_code;
        store_wr.level_en  = in_acc && (s_kind == KIND_LEVEL);
        store_wr.level     = s_level;
        rd_addr = line_reg ? STORE_AW'(SLOTS_PER_LINE) + STORE_AW'(slot_count_reg)
                           : STORE_AW'(slot_count_reg);
    end

    clnr_text_store u_text_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (store_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // byte to send in this step
    always_comb begin
        send_active = 1'b0;
        send_rs     = 1'b0;
        send_byte   = function_set_reg;
        if (!init_done_reg) begin
            case (phase_reg)
                PH_FUNC: begin
                    send_active = 1'b1;
                    send_byte   = function_set_reg;
                end
                PH_DISP: begin
                    send_active = 1'b1;
                    send_byte   = display_control_reg;
                end
                PH_MODE: begin
                    send_active = 1'b1;
                    send_byte   = function_set_reg;
                end
                default: begin
                    send_active = 1'b0;
                end
            endcase
        end else if (line_busy) begin
            send_active = 1'b1;
            send_rs     = 1'b1;
            send_byte   = rd_data;
        end else if (!line_reg) begin
            send_active = 1'b1;
            send_byte   = line_two_addr_reg;
        end else begin
            send_active = 1'b1;
            send_byte   = line_one_addr_reg;
        end
    end

    // one strobe step: high nibble up, down, low nibble up, down
    always_comb begin
        if (!low_half_reg) begin
            step_nibble = send_byte[7:4];
            step_enable = !pin_enable_reg;
            step_low    = pin_enable_reg;
            step_done   = 1'b0;
        end else begin
            step_nibble = send_byte[3:0];
            step_enable = !pin_enable_reg;
            step_low    = !pin_enable_reg;
            step_done   = pin_enable_reg;
        end
    end

    assign restart = init_done_reg && !line_busy && line_reg && step_done;

    // next state
    always_comb begin
        power_up_delay_next  = power_up_delay_reg;
        command_gap_next     = command_gap_reg;
        function_set_next    = function_set_reg;
        display_control_next = display_control_reg;
        line_one_addr_next   = line_one_addr_reg;
        line_two_addr_next   = line_two_addr_reg;
        pin_nibble_next      = pin_nibble_reg;
        pin_rs_next          = pin_rs_reg;
        pin_enable_next      = pin_enable_reg;
        low_half_next        = low_half_reg;
        init_done_next       = init_done_reg;
        phase_next           = phase_reg;
        delay_count_next     = delay_count_reg;
        after_phase_next     = after_phase_reg;
        line_next            = line_reg;
        slot_count_next      = slot_count_reg;

        if (tick_acc) begin
            if (send_active) begin
                pin_rs_next     = send_rs;
                pin_nibble_next = step_nibble;
                pin_enable_next = step_enable;
                low_half_next   = step_low;
            end
            if (!init_done_reg) begin
                case (phase_reg)
                    PH_FUNC: begin
                        if (step_done) begin
                            delay_count_next = command_gap_reg;
                            after_phase_next = PH_DISP;
                            phase_next       = PH_DELAY;
                        end
                    end
                    PH_DISP: begin
                        if (step_done) begin
                            delay_count_next = command_gap_reg;
                            after_phase_next = PH_MODE;
                            phase_next       = PH_DELAY;
                        end
                    end
                    PH_MODE: begin
                        if (step_done) begin
                            phase_next     = PH_FUNC;
                            init_done_next = 1'b1;
                        end
                    end
                    default: begin
                        if (delay_count_reg != 8'd0) begin
                            delay_count_next = delay_count_reg - 8'd1;
                        end else begin
                            phase_next = after_phase_reg;
                        end
                    end
                endcase
            end else if (line_busy) begin
                if (step_done) begin
                    slot_count_next = slot_count_reg + SLOT_CW'(1);
                end
            end else if (!line_reg) begin
                if (step_done) begin
                    slot_count_next = '0;
                    line_next       = 1'b1;
                end
            end else begin
                if (step_done) begin
                    slot_count_next = '0;
                    line_next       = 1'b0;
                    pin_rs_next     = 1'b0;
                    pin_nibble_next = MODE_NIBBLE;
                    pin_enable_next = 1'b0;
                    init_done_next  = 1'b0;
                end
            end
        end

        if (cfg_acc) begin
            case (cfg_index)
                CFG_POWER_UP_DELAY: begin
                    power_up_delay_next = cfg_data;
                    if (!init_done_reg && (phase_reg == PH_DELAY)
                        && (after_phase_reg == PH_FUNC)) begin
                        delay_count_next = cfg_data;
                    end
                end
                CFG_COMMAND_GAP:     command_gap_next     = cfg_data;
                CFG_FUNCTION_SET:    function_set_next    = cfg_data;
                CFG_DISPLAY_CONTROL: display_control_next = cfg_data;
                CFG_LINE_ONE_ADDR:   line_one_addr_next   = cfg_data;
                CFG_LINE_TWO_ADDR:   line_two_addr_next   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // first result of a tick: pin levels right after the strobe step
    always_comb begin
        res_rs     = send_active ? send_rs : pin_rs_reg;
        res_nibble = send_active ? step_nibble : pin_nibble_reg;
        res_enable = send_active ? step_enable : pin_enable_reg;
        res_ready  = init_done_reg || init_done_next;
        res_last   = !restart;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_up_delay_reg  <= RST_POWER_UP_DELAY;
            command_gap_reg     <= RST_COMMAND_GAP;
            function_set_reg    <= RST_FUNCTION_SET;
            display_control_reg <= RST_DISPLAY_CONTROL;
            line_one_addr_reg   <= RST_LINE_ONE_ADDR;
            line_two_addr_reg   <= RST_LINE_TWO_ADDR;
            pin_nibble_reg      <= MODE_NIBBLE;
            pin_rs_reg          <= 1'b0;
            pin_enable_reg      <= 1'b0;
            low_half_reg        <= 1'b0;
            init_done_reg       <= 1'b0;
            phase_reg           <= PH_DELAY;
            delay_count_reg     <= RST_POWER_UP_DELAY;
            after_phase_reg     <= PH_FUNC;
            line_reg            <= 1'b0;
            slot_count_reg      <= '0;
        end else begin
            power_up_delay_reg  <= power_up_delay_next;
            command_gap_reg     <= command_gap_next;
            function_set_reg    <= function_set_next;
            display_control_reg <= display_control_next;
            line_one_addr_reg   <= line_one_addr_next;
            line_two_addr_reg   <= line_two_addr_next;
            pin_nibble_reg      <= pin_nibble_next;
            pin_rs_reg          <= pin_rs_next;
            pin_enable_reg      <= pin_enable_next;
            low_half_reg        <= low_half_next;
            init_done_reg       <= init_done_next;
            phase_reg           <= phase_next;
            delay_count_reg     <= delay_count_next;
            after_phase_reg     <= after_phase_next;
            line_reg            <= line_next;
            slot_count_reg      <= slot_count_next;
        end
    end

    // output control: valid flag and the 4-bit mode strobe tail
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            tail_reg    <= 2'd0;
        end else if (tick_acc) begin
            m_valid_reg <= 1'b1;
            tail_reg    <= restart ? 2'd2 : 2'd0;
        end else if (m_valid_reg && m_ready) begin
            if (tail_reg != 2'd0) begin
                tail_reg <= tail_reg - 2'd1;
            end else begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            m_rs_reg        <= res_rs;
            m_nibble_reg    <= res_nibble;
            m_enable_reg    <= res_enable;
            m_ready_res_reg <= res_ready;
            m_last_reg      <= res_last;
        end else if (m_valid_reg && m_ready && (tail_reg != 2'd0)) begin
            m_rs_reg        <= 1'b0;
            m_nibble_reg    <= MODE_NIBBLE;
            m_enable_reg    <= (tail_reg == 2'd2);
            m_ready_res_reg <= 1'b0;
            m_last_reg      <= (tail_reg == 2'd1);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reg_select  = m_rs_reg;
    assign m_read_write  = 1'b0;
    assign m_data_nibble = m_nibble_reg;
    assign m_enable      = m_enable_reg;
    assign m_ready_res   = m_ready_res_reg;
    assign m_last        = m_last_reg;

    a_tail_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_reg != 2'd0) |-> (m_valid_reg && !m_last_reg))
        else $error("strobe tail pending without a non-final result held");

    a_tail_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_reg == 2'd1) |-> (m_nibble_reg == MODE_NIBBLE || m_valid_reg && m_enable_reg
                                || !m_ready_res_reg))
        else $error("strobe tail out of order");

    a_no_wait_mid_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        !(low_half_reg && !init_done_reg && (phase_reg == PH_DELAY)))
        else $error("wait entered in the middle of a byte");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_count_reg <= SLOT_CW'(SLOTS_PER_LINE))
        else $error("slot count beyond line length");

    a_restart_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_acc && restart) |=> (tail_reg == 2'd2 && !init_done_reg))
        else $error("line two end did not start the mode strobe");

endmodule

// ----- tb/char_lcd_nibble_refresh_controller_test.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_refresh_controller_test
// Self-checking testbench for the 4-bit character LCD refresh controller.
// A shadow of the controller (registers, text store, strobe sequencer) runs
// on every accepted item. The pin levels it predicts are queued and compared
// field by field with each result taken from the m_ channel. The test covers
// directed start-up and store writes, random traffic at full rate and with
// sender and receiver idling, and a long output stall backing up the input.
// ----------------------------------------------------------------------------
module char_lcd_nibble_refresh_controller_test;
    import clnr_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [2:0] CFG_SPARE_A  = 3'd6;
    localparam logic [2:0] CFG_SPARE_B  = 3'd7;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         STALL_CYCLES = 80;

    localparam logic [127:0] BANNER_ONE =
        128'h464F4220_54657374_65722020_20202020;
    localparam logic [127:0] BANNER_TWO =
        128'h4F6D6172_20536576_696C6C61_20202020;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic [3:0] nib;
        logic       en;
        logic       rdy;
        logic       last;
    } pins_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       line;
        logic [3:0] slot;
        logic [7:0] ch;
        logic [7:0] level;
    } lcd_item_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index     = '0;
    logic [7:0] cfg_data      = '0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind        = '0;
    logic       s_line_select = 1'b0;
    logic [3:0] s_slot        = '0;
    logic [7:0] s_char_code   = '0;
    logic [7:0] s_level       = '0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_reg_select;
    logic       m_read_write;
    logic [3:0] m_data_nibble;
    logic       m_enable;
    logic       m_ready_res;
    logic       m_last;

    // shadow registers and state
    logic [7:0]         reg_pud, reg_gap, reg_fset, reg_dctl, reg_l1, reg_l2;
    logic [7:0]         shadow_text [STORE_DEPTH];
    logic [3:0]         p_nib;
    logic               p_rs, p_en, low_half, init_done, cur_line;
    phase_t             phase, phase_next;
    logic [7:0]         wait_cnt;
    logic [SLOT_CW-1:0] slot_cnt;

    pins_t pin_levels_q[$];
    int    mismatches = 0;
    int    snd_idle   = 0;
    int    rcv_idle   = 0;
    bit    hold_req   = 1'b0;
    int    hold_left  = 0;

    char_lcd_nibble_refresh_controller i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_line_select (s_line_select),
        .s_slot        (s_slot),
        .s_char_code   (s_char_code),
        .s_level       (s_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reg_select  (m_reg_select),
        .m_read_write  (m_read_write),
        .m_data_nibble (m_data_nibble),
        .m_enable      (m_enable),
        .m_ready_res   (m_ready_res),
        .m_last        (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------
    function automatic void shadow_reset();
        reg_pud  = RST_POWER_UP_DELAY;
        reg_gap  = RST_COMMAND_GAP;
        reg_fset = RST_FUNCTION_SET;
        reg_dctl = RST_DISPLAY_CONTROL;
        reg_l1   = RST_LINE_ONE_ADDR;
        reg_l2   = RST_LINE_TWO_ADDR;
        for (int i = 0; i < SLOTS_PER_LINE; i++) begin
            shadow_text[i]                  = BANNER_ONE[127 - 8*i -: 8];
            shadow_text[SLOTS_PER_LINE + i] = BANNER_TWO[127 - 8*i -: 8];
        end
        p_nib      = MODE_NIBBLE;
        p_rs       = 1'b0;
        p_en       = 1'b0;
        low_half   = 1'b0;
        init_done  = 1'b0;
        phase      = PH_DELAY;
        wait_cnt   = reg_pud;
        phase_next = PH_FUNC;
        cur_line   = 1'b0;
        slot_cnt   = '0;
    endfunction

    function automatic void shadow_config(logic [2:0] idx, logic [7:0] val);
        case (idx)
            CFG_POWER_UP_DELAY: begin
                reg_pud = val;
                // still in the power-up wait: the count restarts
                if (!init_done && phase == PH_DELAY && phase_next == PH_FUNC)
                    wait_cnt = val;
            end
            CFG_COMMAND_GAP:     reg_gap  = val;
            CFG_FUNCTION_SET:    reg_fset = val;
            CFG_DISPLAY_CONTROL: reg_dctl = val;
            CFG_LINE_ONE_ADDR:   reg_l1   = val;
            CFG_LINE_TWO_ADDR:   reg_l2   = val;
            default: ;
        endcase
    endfunction

    function automatic void push_pins(logic rdy, logic last);
        pins_t p;
        p.rs   = p_rs;
        p.rw   = 1'b0;
        p.nib  = p_nib;
        p.en   = p_en;
        p.rdy  = rdy;
        p.last = last;
        pin_levels_q.push_back(p);
    endfunction

    // one enable step of a byte; returns 1 once both nibbles are strobed
    function automatic bit strobe_byte(logic rs, logic [7:0] b);
        p_rs = rs;
        if (!low_half) begin
            p_nib = b[7:4];
            if (!p_en) begin
                p_en = 1'b1;
            end else begin
                low_half = 1'b1;
                p_en     = 1'b0;
            end
            return 1'b0;
        end
        p_nib = b[3:0];
        if (!p_en) begin
            p_en = 1'b1;
            return 1'b0;
        end
        low_half = 1'b0;
        p_en     = 1'b0;
        return 1'b1;
    endfunction

    function automatic void start_wait(logic [7:0] ticks, phase_t nxt);
        wait_cnt   = ticks;
        phase_next = nxt;
        phase      = PH_DELAY;
    endfunction

    function automatic void put_char(logic line, int pos, logic [7:0] v);
        if (pos < SLOTS_PER_LINE)
            shadow_text[int'(line) * SLOTS_PER_LINE + pos] = v;
    endfunction

    function automatic void advance_pins();
        int idx;
        if (!init_done) begin
            case (phase)
                PH_FUNC: if (strobe_byte(1'b0, reg_fset)) start_wait(reg_gap, PH_DISP);
                PH_DISP: if (strobe_byte(1'b0, reg_dctl)) start_wait(reg_gap, PH_MODE);
                PH_MODE: begin
                    if (strobe_byte(1'b0, reg_fset)) begin
                        phase     = PH_FUNC;
                        init_done = 1'b1;
                    end
                end
                default: begin
                    if (wait_cnt != 0)
                        wait_cnt--;
                    else
                        phase = phase_next;
                end
            endcase
            push_pins(init_done, 1'b1);
            return;
        end
        if (slot_cnt < SLOTS_PER_LINE) begin
            idx = int'(cur_line) * SLOTS_PER_LINE + int'(slot_cnt);
            if (strobe_byte(1'b1, shadow_text[idx]))
                slot_cnt++;
        end else if (!cur_line) begin
            if (strobe_byte(1'b0, reg_l2)) begin
                slot_cnt = '0;
                cur_line = 1'b1;
            end
        end else if (strobe_byte(1'b0, reg_l1)) begin
            // end of line two: re-strobe 4-bit mode and restart init
            slot_cnt = '0;
            cur_line = 1'b0;
            push_pins(1'b1, 1'b0);
            p_rs      = 1'b0;
            p_nib     = MODE_NIBBLE;
            p_en      = 1'b1;
            init_done = 1'b0;
            push_pins(1'b0, 1'b0);
            p_en = 1'b0;
            push_pins(1'b0, 1'b1);
            return;
        end
        push_pins(1'b1, 1'b1);
    endfunction

    function automatic void apply_item(lcd_item_t it);
        int lv;
        lv = int'(it.level);
        case (it.kind)
            KIND_TICK: advance_pins();
            KIND_CHAR: put_char(it.line, int'(it.slot), it.ch);
            KIND_LEVEL: begin
                put_char(1'b0, 0, ASCII_ZERO + 8'(lv / 100));
                put_char(1'b0, 1, ASCII_ZERO + 8'((lv / 10) % 10));
                put_char(1'b0, 2, ASCII_ZERO + 8'(lv % 10));
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        pins_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pin_levels_q.size() == 0) begin
                report("unexpected result, nibble", 8'(m_data_nibble), 8'h00);
            end else begin
                want = pin_levels_q.pop_front();
                if (m_reg_select !== want.rs)  report("reg_select", 8'(m_reg_select), 8'(want.rs));
                if (m_read_write !== want.rw)  report("read_write", 8'(m_read_write), 8'(want.rw));
                if (m_data_nibble !== want.nib)
                    report("data_nibble", 8'(m_data_nibble), 8'(want.nib));
                if (m_enable !== want.en)      report("enable", 8'(m_enable), 8'(want.en));
                if (m_ready_res !== want.rdy)  report("ready_res", 8'(m_ready_res), 8'(want.rdy));
                if (m_last !== want.last)      report("last", 8'(m_last), 8'(want.last));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = STALL_CYCLES - 1;
            m_ready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_item(lcd_item_t it);
        s_valid       <= 1'b1;
        s_kind        <= it.kind;
        s_line_select <= it.line;
        s_slot        <= it.slot;
        s_char_code   <= it.ch;
        s_level       <= it.level;
        do @(posedge aclk); while (s_ready !== 1'b1);
        apply_item(it);
        if ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < snd_idle);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        shadow_config(idx, val);
    endtask

    task automatic configure(logic [7:0] pud, logic [7:0] gap, logic [7:0] fset,
                             logic [7:0] dctl, logic [7:0] l1, logic [7:0] l2);
        write_reg(CFG_POWER_UP_DELAY, pud);
        write_reg(CFG_COMMAND_GAP, gap);
        write_reg(CFG_FUNCTION_SET, fset);
        write_reg(CFG_DISPLAY_CONTROL, dctl);
        write_reg(CFG_LINE_ONE_ADDR, l1);
        write_reg(CFG_LINE_TWO_ADDR, l2);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pin_levels_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic lcd_item_t make_item(logic [1:0] kind);
        lcd_item_t it;
        it.kind  = kind;
        it.line  = 1'($urandom_range(1));
        it.slot  = 4'($urandom_range(15));
        it.ch    = 8'($urandom_range(255));
        it.level = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic lcd_item_t random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)      return make_item(KIND_TICK);
        else if (pick < 91) return make_item(KIND_CHAR);
        else if (pick < 96) return make_item(KIND_LEVEL);
        return make_item(KIND_UNUSED);
    endfunction

    task automatic run_random(int count);
        repeat (count) send_item(random_item());
    endtask

    task automatic test_power_up_and_writes();
        lcd_item_t it;
        // power-up delay reloads the wait count; unknown indexes are ignored
        write_reg(CFG_SPARE_A, 8'h00);
        write_reg(CFG_SPARE_B, 8'hFF);
        configure(8'd3, 8'd0, 8'h00, 8'hFF, 8'hFF, 8'h00);
        it = make_item(KIND_CHAR);
        it.line = 1'b0; it.slot = 4'd0;  it.ch = 8'h00; send_item(it);
        it.line = 1'b1; it.slot = 4'd15; it.ch = 8'hFF; send_item(it);
        it.line = 1'b0; it.slot = 4'd15; it.ch = 8'hA5; send_item(it);
        it.line = 1'b1; it.slot = 4'd0;  it.ch = 8'h5A; send_item(it);
        it = make_item(KIND_LEVEL);
        it.level = 8'd0;   send_item(it);
        it.level = 8'd255; send_item(it);
        it.level = 8'd99;  send_item(it);
        it = '1;
        it.kind = KIND_UNUSED;
        send_item(it);
        repeat (17) send_item(make_item(KIND_TICK));
    endtask

    task automatic test_sender_idle();
        drain();
        configure(8'($urandom_range(255)), 8'($urandom_range(3)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        snd_idle = 38;
        rcv_idle = 48;
        run_random(120);
    endtask

    task automatic test_receiver_idle();
        drain();
        configure(8'd0, 8'd2, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        snd_idle = 48;
        rcv_idle = 38;
        run_random(120);
    endtask

    task automatic test_full_rate_long_gap();
        drain();
        configure(8'd255, 8'd255, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        snd_idle = 0;
        rcv_idle = 0;
        run_random(120);
    endtask

    task automatic test_output_stall();
        snd_idle = 0;
        rcv_idle = 0;
        hold_req = 1'b1;
        repeat (30) send_item(make_item(KIND_TICK));
    endtask

    initial begin
        shadow_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_power_up_and_writes();
        test_sender_idle();
        test_receiver_idle();
        test_full_rate_long_gap();
        test_output_stall();
        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("FAIL");
        $finish;
    end

endmodule
